FILE: rtl/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    // Binary input width and bit counter
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(VALUE_W);

    // One BCD digit
    localparam int DIGIT_W = 4;

    // Output character
    localparam int CHAR_W  = 6;
    localparam int TDATA_W = 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Digits at or above this get +3 before the shift
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

endpackage

FILE: rtl/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// An input beat runs 32 shift-add-3 steps, then a scan that drops one suppressed
// leading zero per step, then the digits go out through the output register.
// A new value is taken only once the last digit of the previous one is registered;
// the single shared shift-add-3 unit converts, and one digit is emitted per cycle while m_tready allows.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts a 32-bit unsigned value to decimal ASCII digits, most significant
// first, leading zeros suppressed, tlast on the least significant digit.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [b2da_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b2da_pkg::TDATA_W-1:0]      m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                              m_tlast    // last
);
    import b2da_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic [BCD_W-1:0]       bcd_step;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   out_free;

    // Shared shift-add-3 unit
    b2da_dd_step #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_step (
        .bcd_in  (bcd_reg),
        .bit_in  (bin_reg[VALUE_W-1]),
        .bcd_out (bcd_step)
    );

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign out_free  = !m_tvalid_reg || m_tready;

    // Sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    bin_next   = s_tdata;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_step;
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    rem_next   = REM_FULL;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, keep at least one digit
                if (top_digit == '0 && rem_reg != REM_ONE) begin
                    bcd_next = bcd_reg << DIGIT_W;
                    rem_next = rem_reg - REM_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    char_next     = ASCII_ZERO + CHAR_W'(top_digit);
                    last_next     = (rem_reg == REM_ONE);
                    m_tvalid_next = 1'b1;
                    bcd_next      = bcd_reg << DIGIT_W;
                    rem_next      = rem_reg - REM_W'(1);
                    if (rem_reg == REM_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            rem_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            rem_reg      <= rem_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-CHAR_W){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

    // Accepted beat starts a fresh conversion
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONV && cnt_reg == '0 && !s_tready))
        else $error("conversion did not start after input beat");

    // Conversion ends after exactly the last bit with a full digit count
    a_conv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg == CNT_LAST) |=>
        (state_reg == ST_SKIP && rem_reg == REM_FULL))
        else $error("conversion did not hand over to digit scan");

    // Emission never runs with no digits left
    a_emit_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> (rem_reg != '0))
        else $error("digit count underflow");

    // Every output character is a decimal digit
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (char_reg >= ASCII_ZERO && char_reg <= ASCII_ZERO + CHAR_W'(9)))
        else $error("output character out of digit range");

endmodule

FILE: rtl/b2da_dd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_dd_step
// One shift-add-3 step: adjusts every BCD digit that is 5 or more by +3, then
// shifts the BCD word left by one and brings in the next binary bit. The bit
// leaving the top digit is dropped, so the word holds the value modulo
// 10^NUM_DIGITS.
// ----------------------------------------------------------------------------
module b2da_dd_step #(
    parameter int NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS*4-1:0] bcd_in,
    input  logic                    bit_in,
    output logic [NUM_DIGITS*4-1:0] bcd_out
);
    import b2da_pkg::*;

    logic [NUM_DIGITS*DIGIT_W-1:0] adj;

    // Per-digit correction, digits are independent
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[d*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
                adj[d*DIGIT_W +: DIGIT_W] = bcd_in[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = bcd_in[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Shift in the next binary bit
    assign bcd_out = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_in};

endmodule
